@@ hw/rtl/assert_macros.svh @@
// Concurrent assertion helpers, sampled on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge.
`define RXD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define RXD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rxd_pkg.sv @@
package rxd_pkg;

  // Ring size in bytes, a power of two; offsets wrap at this size
  localparam int unsigned RING_BYTES = 32768;
  localparam int unsigned OFS_W      = $clog2(RING_BYTES);
  localparam int unsigned SUM_W      = ((OFS_W > 16) ? OFS_W : 16) + 1;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned MAX_LEN_W  = 11;
  localparam int unsigned NXO_W      = 15;
  localparam int unsigned PTR_W      = 16;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(1536);
  localparam logic [LEN_W-1:0]     HDR_BYTES     = LEN_W'(4);
  localparam logic [PTR_W-1:0]     PTR_LAG       = PTR_W'(16);
  localparam int unsigned          STATUS_OK_BIT = 0;

  // Header byte being taken
  typedef enum logic [1:0] {
    HDR_STAT_LO = 2'd0,
    HDR_STAT_HI = 2'd1,
    HDR_LEN_LO  = 2'd2,
    HDR_LEN_HI  = 2'd3
  } hdr_e;

endpackage

@@ hw/rtl/rx_ring_frame_deframer.sv @@
// The accepting edge loads the input register and a later advance loads the result register,
// so out_valid_o rises once the held byte moves on; that move waits while the result side
// stalls.
// Throughput: one byte per cycle unless the result side stalls; the per-byte header/payload
// step is a single compare-and-add pass between the two registers.
// Reset: header phase at ring offset 0, max_frame_length 1536, both registers empty.
`include "assert_macros.svh"

module rx_ring_frame_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rxd_pkg::MAX_LEN_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rxd_pkg::BYTE_W-1:0]    ring_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rxd_pkg::BYTE_W-1:0]    payload_byte_o,
  output logic                          payload_valid_o,
  output logic                          frame_last_o,
  output logic                          frame_error_o,
  output logic [rxd_pkg::NXO_W-1:0]     next_offset_o,
  output logic [rxd_pkg::PTR_W-1:0]     read_pointer_o,
  output logic                          read_pointer_update_o
);
  import rxd_pkg::*;

  // Configuration
  logic [MAX_LEN_W-1:0] max_len_q;

  // Input register
  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;

  // Parser state
  hdr_e              hc_q, hc_d;
  logic              in_payload_q, in_payload_d;
  logic [OFS_W-1:0]  frame_start_q, frame_start_d;
  logic [OFS_W-1:0]  ring_offset_q, ring_offset_d;
  logic [OFS_W-1:0]  next_start_q, next_start_d;
  logic [MAX_LEN_W-1:0] bytes_left_q, bytes_left_d;
  logic              status_ok_q, status_ok_d;
  logic [BYTE_W-1:0] len_lo_q, len_lo_d;

  // Result register
  logic              out_vld_q, out_vld_d;
  logic [BYTE_W-1:0] pbyte_q, pbyte_d;
  logic              pvalid_q, pvalid_d;
  logic              last_q, last_d;
  logic              err_q, err_d;
  logic [OFS_W-1:0]  nxo_q;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic              rupd_q, rupd_d;

  // Handshake: advance moves the held request through the parser into the
  // result register; the input register refills in the same cycle.
  logic advance;
  logic in_accept;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Header checks, evaluated on the last header byte
  logic [LEN_W-1:0] hdr_len;
  logic             hdr_bad;
  logic             hdr_empty;
  logic [SUM_W-1:0] start_sum;
  logic [OFS_W-1:0] hdr_next_start;
  logic [OFS_W-1:0] hdr_next_ofs;
  logic             pay_last;

  assign hdr_len   = {in_byte_q, len_lo_q};
  assign hdr_bad   = (hdr_len < HDR_BYTES) || (hdr_len > LEN_W'(max_len_q)) || !status_ok_q;
  assign hdr_empty = (hdr_len == HDR_BYTES);
  // Next frame start: past header and CRC, rounded up to a 4-byte boundary
  assign start_sum = SUM_W'(frame_start_q) + SUM_W'(hdr_len) + SUM_W'(7);
  assign hdr_next_start = OFS_W'(start_sum) & ~OFS_W'(3);
  assign hdr_next_ofs   = frame_start_q + OFS_W'(hc_q) + OFS_W'(1);
  // Payload ends when the count drops to zero (or already sits there)
  assign pay_last  = (bytes_left_q <= MAX_LEN_W'(1));

  // Next parser state
  always_comb begin
    hc_d          = hc_q;
    in_payload_d  = in_payload_q;
    frame_start_d = frame_start_q;
    ring_offset_d = ring_offset_q;
    next_start_d  = next_start_q;
    bytes_left_d  = bytes_left_q;
    status_ok_d   = status_ok_q;
    len_lo_d      = len_lo_q;
    if (in_payload_q) begin
      if (bytes_left_q != '0) begin
        bytes_left_d = bytes_left_q - MAX_LEN_W'(1);
      end
      if (pay_last) begin
        frame_start_d = next_start_q;
        ring_offset_d = next_start_q;
        in_payload_d  = 1'b0;
        hc_d          = HDR_STAT_LO;
      end else begin
        ring_offset_d = ring_offset_q + OFS_W'(1);
      end
    end else begin
      unique case (hc_q)
        HDR_STAT_LO: begin
          status_ok_d   = in_byte_q[STATUS_OK_BIT];
          hc_d          = HDR_STAT_HI;
          ring_offset_d = hdr_next_ofs;
        end
        HDR_STAT_HI: begin
          hc_d          = HDR_LEN_LO;
          ring_offset_d = hdr_next_ofs;
        end
        HDR_LEN_LO: begin
          len_lo_d      = in_byte_q;
          hc_d          = HDR_LEN_HI;
          ring_offset_d = hdr_next_ofs;
        end
        HDR_LEN_HI: begin
          hc_d = HDR_STAT_LO;
          if (hdr_bad) begin
            // Restart the ring from offset 0
            frame_start_d = '0;
            ring_offset_d = '0;
          end else if (hdr_empty) begin
            frame_start_d = hdr_next_start;
            ring_offset_d = hdr_next_start;
          end else begin
            in_payload_d  = 1'b1;
            next_start_d  = hdr_next_start;
            bytes_left_d  = MAX_LEN_W'(hdr_len - HDR_BYTES);
            ring_offset_d = frame_start_q + OFS_W'(4);
          end
        end
        default: begin
          hc_d = HDR_STAT_LO;
        end
      endcase
    end
  end

  // Result fields
  always_comb begin
    pbyte_d  = '0;
    pvalid_d = 1'b0;
    last_d   = 1'b0;
    err_d    = 1'b0;
    rptr_d   = '0;
    rupd_d   = 1'b0;
    if (in_payload_q) begin
      pbyte_d  = in_byte_q;
      pvalid_d = 1'b1;
      if (pay_last) begin
        last_d = 1'b1;
        rptr_d = PTR_W'(next_start_q) - PTR_LAG;
        rupd_d = 1'b1;
      end
    end else if (hc_q == HDR_LEN_HI) begin
      if (hdr_bad) begin
        err_d  = 1'b1;
        rupd_d = 1'b1;
      end else if (hdr_empty) begin
        last_d = 1'b1;
        rptr_d = PTR_W'(hdr_next_start) - PTR_LAG;
        rupd_d = 1'b1;
      end
    end
  end

  // Hold the result until taken; drop valid once it leaves
  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q     <= MAX_LEN_RESET;
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      hc_q          <= HDR_STAT_LO;
      in_payload_q  <= 1'b0;
      frame_start_q <= '0;
      ring_offset_q <= '0;
      next_start_q  <= '0;
      bytes_left_q  <= '0;
      status_ok_q   <= 1'b0;
      len_lo_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      out_vld_q <= out_vld_d;
      if (advance) begin
        hc_q          <= hc_d;
        in_payload_q  <= in_payload_d;
        frame_start_q <= frame_start_d;
        ring_offset_q <= ring_offset_d;
        next_start_q  <= next_start_d;
        bytes_left_q  <= bytes_left_d;
        status_ok_q   <= status_ok_d;
        len_lo_q      <= len_lo_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= ring_byte_i;
    end
    if (advance) begin
      pbyte_q  <= pbyte_d;
      pvalid_q <= pvalid_d;
      last_q   <= last_d;
      err_q    <= err_d;
      nxo_q    <= ring_offset_d;
      rptr_q   <= rptr_d;
      rupd_q   <= rupd_d;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign payload_byte_o        = pbyte_q;
  assign payload_valid_o       = pvalid_q;
  assign frame_last_o          = last_q;
  assign frame_error_o         = err_q;
  assign next_offset_o         = NXO_W'(nxo_q);
  assign read_pointer_o        = rptr_q;
  assign read_pointer_update_o = rupd_q;

  `RXD_ASSERT_IMPL(a_err_restart, out_vld_q && err_q,
    rupd_q && (rptr_q == '0) && (nxo_q == '0) && !pvalid_q && !last_q,
    "header error must restart at offset 0 with a zero pointer")
  `RXD_ASSERT_IMPL(a_last_updates_ptr, out_vld_q && last_q,
    rupd_q && (nxo_q[1:0] == 2'b00) && (rptr_q == PTR_W'(nxo_q) - PTR_LAG),
    "frame end must jump to an aligned start and report the lagged pointer")
  `RXD_ASSERT_IMPL(a_ptr_only_at_end, out_vld_q && rupd_q, last_q || err_q,
    "pointer update outside a frame end or error")
  `RXD_ASSERT(a_payload_count, !in_payload_q || (bytes_left_q != '0),
    "payload phase entered with nothing left to emit")

endmodule
